>>> rtl/tai_pkg.sv
// Shared types, constants and codes of the triangle attribute interpolator.
package tai_pkg;

  localparam int VTX_DEPTH    = 1024;
  localparam int TRI_DEPTH    = 1024;
  localparam int INDEX_STRIDE = 3;
  localparam int IDX_DEPTH    = TRI_DEPTH * INDEX_STRIDE;
  localparam int VTX_AW       = $clog2(VTX_DEPTH);
  localparam int IDX_AW       = $clog2(IDX_DEPTH);
  localparam int ACC_W        = 62;
  localparam int WGT_W        = 19;
  localparam int QUO_W        = 17;
  localparam int LEN_W        = 32;
  localparam int RT_W         = 64;
  localparam int SUM_W        = 62;

  localparam logic [2:0] ACT_INDEX    = 3'd0;
  localparam logic [2:0] ACT_POSITION = 3'd1;
  localparam logic [2:0] ACT_NORMAL   = 3'd2;
  localparam logic [2:0] ACT_TANGENT  = 3'd3;
  localparam logic [2:0] ACT_TEXCOORD = 3'd4;
  localparam logic [2:0] ACT_QUERY    = 3'd5;

  localparam logic [3:0] ACC_NX = 4'd0;
  localparam logic [3:0] ACC_TX = 4'd3;
  localparam logic [3:0] ACC_S  = 4'd6;
  localparam logic [3:0] ACC_GX = 4'd8;
  localparam logic [3:0] ACC_GY = 4'd9;
  localparam logic [3:0] ACC_GZ = 4'd10;
  localparam int         ACC_N  = 11;

  typedef logic signed [31:0]       q16_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic [VTX_AW-1:0]        vtx_addr_t;
  typedef logic [IDX_AW-1:0]        idx_addr_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] slot;
    vtx_addr_t   vertex_number;
    q16_t        comp_x;
    q16_t        comp_y;
    q16_t        comp_z;
    logic [9:0]  triangle;
    logic [16:0] bary_u;
    logic [16:0] bary_v;
  } in_item_t;

  typedef struct packed {
    q16_t shade_nx;
    q16_t shade_ny;
    q16_t shade_nz;
    q16_t tan_x;
    q16_t tan_y;
    q16_t tan_z;
    q16_t tex_s;
    q16_t tex_t;
    q16_t geo_nx;
    q16_t geo_ny;
    q16_t geo_nz;
  } out_item_t;

  typedef struct packed {
    logic      idx_we;
    logic      pos_we;
    logic      nrm_we;
    logic      tan_we;
    logic      tex_we;
    idx_addr_t idx_addr;
    vtx_addr_t vtx_addr;
    vtx_addr_t vnum;
    q16_t      x;
    q16_t      y;
    q16_t      z;
  } wr_t;

  typedef struct packed {
    logic      idx_re;
    idx_addr_t idx_addr;
    logic      vtx_re;
    vtx_addr_t vtx_addr;
  } rd_t;

  typedef struct packed {
    q16_t [2:0] pos;
    q16_t [2:0] nrm;
    q16_t [2:0] tan;
    q16_t [1:0] tex;
  } vtx_data_t;

  typedef enum logic [3:0] {
    C_IDLE, C_IDX, C_VTX, C_MAC, C_EDGE, C_ESCALE, C_CROSS, C_FLUSH,
    C_NORM, C_NWAIT, C_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

endpackage

>>> rtl/tai_in_if.sv
// Input channel: valid/ready handshake with one input item.
interface tai_in_if;
  logic               valid;
  logic               ready;
  tai_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> rtl/tai_out_if.sv
// Output channel: valid/ready handshake with one result item.
interface tai_out_if;
  logic               valid;
  logic               ready;
  tai_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> rtl/tai_store.sv
// Mesh memories: index store and per-vertex attribute stores.
module tai_store (
  input  logic                clk,
  input  tai_pkg::wr_t        wr,
  input  tai_pkg::rd_t        rd,
  output tai_pkg::vtx_addr_t  idx_rdata,
  output tai_pkg::vtx_data_t  vtx_rdata
);

  tai_pkg::vtx_addr_t idx_mem [tai_pkg::IDX_DEPTH];
  tai_pkg::q16_t [2:0] pos_mem [tai_pkg::VTX_DEPTH];
  tai_pkg::q16_t [2:0] nrm_mem [tai_pkg::VTX_DEPTH];
  tai_pkg::q16_t [2:0] tan_mem [tai_pkg::VTX_DEPTH];
  tai_pkg::q16_t [1:0] tex_mem [tai_pkg::VTX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.idx_we) begin
      idx_mem[wr.idx_addr] <= wr.vnum;
    end
    if (rd.idx_re) begin
      idx_rdata <= idx_mem[rd.idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.pos_we) begin
      pos_mem[wr.vtx_addr] <= {wr.z, wr.y, wr.x};
    end
    if (wr.nrm_we) begin
      nrm_mem[wr.vtx_addr] <= {wr.z, wr.y, wr.x};
    end
    if (wr.tan_we) begin
      tan_mem[wr.vtx_addr] <= {wr.z, wr.y, wr.x};
    end
    if (wr.tex_we) begin
      tex_mem[wr.vtx_addr] <= {wr.y, wr.x};
    end
    if (rd.vtx_re) begin
      vtx_rdata.pos <= pos_mem[rd.vtx_addr];
      vtx_rdata.nrm <= nrm_mem[rd.vtx_addr];
      vtx_rdata.tan <= tan_mem[rd.vtx_addr];
      vtx_rdata.tex <= tex_mem[rd.vtx_addr];
    end
  end

endmodule

>>> rtl/tai_norm.sv
// Vector normalizer: scale, sum of squares, bit-serial root and divide.
module tai_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tai_pkg::acc_t       vec [3],
  output logic                done,
  output tai_pkg::q16_t       res [3]
);

  tai_pkg::norm_state_t state, state_next;

  logic [tai_pkg::ACC_W-1:0]   mg [3];
  logic                        neg [3];
  logic [4:0]                  cnt;
  logic [59:0]                 sqp;
  logic [tai_pkg::SUM_W-1:0]   sum;
  logic [tai_pkg::SUM_W-1:0]   sum_add;
  logic [tai_pkg::RT_W-1:0]    n;
  logic [tai_pkg::RT_W-1:0]    r;
  logic [tai_pkg::RT_W-1:0]    rbit;
  logic [tai_pkg::RT_W-1:0]    rt_try;
  logic [tai_pkg::LEN_W-1:0]   len;
  logic [tai_pkg::LEN_W-2:0]   rem [3];
  logic [tai_pkg::QUO_W-1:0]   lo [3];
  logic [tai_pkg::QUO_W-1:0]   q [3];
  logic [46:0]                 dvd [3];
  logic [tai_pkg::LEN_W-1:0]   dtry [3];
  logic                        vzero;
  logic                        big;
  logic                        tiny;
  logic [29:0]                 sq_op;

  always_comb begin
    vzero = 1'b1;
    big   = 1'b0;
    tiny  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (vec[i] != '0) vzero = 1'b0;
      if (mg[i][tai_pkg::ACC_W-1:30] != '0) big = 1'b1;
      if (mg[i][tai_pkg::ACC_W-1:29] != '0) tiny = 1'b0;
    end
    case (cnt[1:0])
      2'd0:    sq_op = mg[0][29:0];
      2'd1:    sq_op = mg[1][29:0];
      default: sq_op = mg[2][29:0];
    endcase
    sum_add = sum + tai_pkg::SUM_W'(sqp);
    rt_try  = r + rbit;
    for (int i = 0; i < 3; i++) begin
      dvd[i]  = {mg[i][29:0], 16'd0} + 47'(r[tai_pkg::LEN_W-1:1]);
      dtry[i] = {rem[i], lo[i][tai_pkg::QUO_W-1]};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tai_pkg::N_IDLE: begin
        if (start) state_next = vzero ? tai_pkg::N_DONE : tai_pkg::N_SCALE;
      end
      tai_pkg::N_SCALE: if (!big && !tiny) state_next = tai_pkg::N_SQ;
      tai_pkg::N_SQ:    if (cnt == 5'd3) state_next = tai_pkg::N_SQRT;
      tai_pkg::N_SQRT:  if (rbit == tai_pkg::RT_W'(1)) state_next = tai_pkg::N_DINIT;
      tai_pkg::N_DINIT: state_next = tai_pkg::N_DIV;
      tai_pkg::N_DIV:   if (cnt == 5'(tai_pkg::QUO_W - 1)) state_next = tai_pkg::N_DONE;
      tai_pkg::N_DONE:  state_next = tai_pkg::N_IDLE;
      default:          state_next = tai_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done = (state == tai_pkg::N_DONE);
    for (int i = 0; i < 3; i++) begin
      res[i] = neg[i] ? tai_pkg::q16_t'(0) - tai_pkg::q16_t'(q[i])
                      : tai_pkg::q16_t'(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tai_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tai_pkg::N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i] < 0;
            mg[i]  <= vec[i] < 0 ? tai_pkg::ACC_W'(-vec[i]) : tai_pkg::ACC_W'(vec[i]);
            q[i]   <= '0;
          end
        end
      end
      tai_pkg::N_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          if (big) mg[i] <= mg[i] >> 1;
          else if (tiny) mg[i] <= mg[i] << 1;
        end
        cnt <= '0;
        sum <= '0;
      end
      tai_pkg::N_SQ: begin
        sqp <= sq_op * sq_op;
        if (cnt != 5'd0) sum <= sum_add;
        cnt <= cnt + 5'd1;
        n    <= tai_pkg::RT_W'(sum_add);
        r    <= '0;
        rbit <= tai_pkg::RT_W'(1) << 62;
      end
      tai_pkg::N_SQRT: begin
        if (n >= rt_try) begin
          n <= n - rt_try;
          r <= (r >> 1) + rbit;
        end else begin
          r <= r >> 1;
        end
        rbit <= rbit >> 2;
      end
      tai_pkg::N_DINIT: begin
        len <= r[tai_pkg::LEN_W-1:0];
        cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          rem[i] <= (tai_pkg::LEN_W-1)'(dvd[i][46:tai_pkg::QUO_W]);
          lo[i]  <= dvd[i][tai_pkg::QUO_W-1:0];
        end
      end
      tai_pkg::N_DIV: begin
        cnt <= cnt + 5'd1;
        for (int i = 0; i < 3; i++) begin
          lo[i] <= lo[i] << 1;
          if (dtry[i] >= len) begin
            rem[i] <= (tai_pkg::LEN_W-1)'(dtry[i] - len);
            q[i]   <= {q[i][tai_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem[i] <= dtry[i][tai_pkg::LEN_W-2:0];
            q[i]   <= {q[i][tai_pkg::QUO_W-2:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tai_ctrl.sv
// Query sequencer: fetch, shared multiply-accumulate, edge cross product, result register.
module tai_ctrl (
  input  logic                clk,
  input  logic                rst,
  tai_in_if.sink              in_ch,
  tai_out_if.source           out_ch,
  output tai_pkg::rd_t        rd,
  input  tai_pkg::vtx_addr_t  idx_rdata,
  input  tai_pkg::vtx_data_t  vtx_rdata,
  output logic                norm_start,
  output tai_pkg::acc_t       norm_vec [3],
  input  logic                norm_done,
  input  tai_pkg::q16_t       norm_res [3]
);

  tai_pkg::ctrl_state_t state, state_next;

  logic [2:0]           cnt;
  logic [2:0]           cnt_m1;
  logic [1:0]           k;
  logic [1:0]           nsel;
  logic [9:0]           tri_num;
  tai_pkg::idx_addr_t   idx_base;
  tai_pkg::wgt_t        w [3];
  tai_pkg::vtx_addr_t   vtx [3];
  tai_pkg::q16_t        p [3][3];
  logic                 esg [6];
  logic [31:0]          emag [6];
  tai_pkg::q16_t        ev [6];
  logic signed [32:0]   d [6];
  logic                 ebig;
  tai_pkg::acc_t        acc [tai_pkg::ACC_N];
  logic signed [63:0]   prod;
  logic                 prod_valid;
  logic [3:0]           prod_dst;
  logic                 prod_neg;
  logic                 mul_en;
  tai_pkg::q16_t        mul_a;
  tai_pkg::q16_t        mul_b;
  logic [3:0]           mul_dst;
  logic                 mul_neg;
  tai_pkg::q16_t        nres [3][3];
  tai_pkg::q16_t        tex [2];
  tai_pkg::acc_t        tround;
  logic                 accept;
  logic                 out_free;
  logic signed [19:0]   w0_full;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign cnt_m1   = cnt - 3'd1;
  assign idx_base = tai_pkg::idx_addr_t'(tri_num) + tai_pkg::idx_addr_t'({tri_num, 1'b0});
  assign w0_full  = 20'sd65536 - $signed({3'd0, in_ch.item.bary_u})
                                - $signed({3'd0, in_ch.item.bary_v});

  always_comb begin
    ebig = 1'b0;
    for (int i = 0; i < 6; i++) begin
      ev[i] = esg[i] ? tai_pkg::q16_t'(0) - tai_pkg::q16_t'(emag[i])
                     : tai_pkg::q16_t'(emag[i]);
      if (emag[i][31:30] != 2'd0) ebig = 1'b1;
    end
    for (int c = 0; c < 3; c++) begin
      d[c]     = 33'(p[1][c]) - 33'(p[0][c]);
      d[c + 3] = 33'(p[2][c]) - 33'(p[0][c]);
    end
    for (int c = 0; c < 2; c++) begin
      tround = (acc[tai_pkg::ACC_S + 4'(c)] + tai_pkg::acc_t'(32768)) >>> 16;
      if (tround > tai_pkg::acc_t'(32'sh7fffffff)) tex[c] = 32'sh7fffffff;
      else if (tround < -tai_pkg::acc_t'(33'sh080000000)) tex[c] = 32'sh80000000;
      else tex[c] = tai_pkg::q16_t'(tround);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tai_pkg::C_IDLE: begin
        if (accept && in_ch.item.action == tai_pkg::ACT_QUERY) state_next = tai_pkg::C_IDX;
      end
      tai_pkg::C_IDX:    if (cnt == 3'd3) state_next = tai_pkg::C_VTX;
      tai_pkg::C_VTX:    state_next = tai_pkg::C_MAC;
      tai_pkg::C_MAC: begin
        if (cnt == 3'd7) state_next = (k == 2'd2) ? tai_pkg::C_EDGE : tai_pkg::C_VTX;
      end
      tai_pkg::C_EDGE:   state_next = tai_pkg::C_ESCALE;
      tai_pkg::C_ESCALE: if (!ebig) state_next = tai_pkg::C_CROSS;
      tai_pkg::C_CROSS:  if (cnt == 3'd5) state_next = tai_pkg::C_FLUSH;
      tai_pkg::C_FLUSH:  state_next = tai_pkg::C_NORM;
      tai_pkg::C_NORM:   state_next = tai_pkg::C_NWAIT;
      tai_pkg::C_NWAIT: begin
        if (norm_done) state_next = (nsel == 2'd2) ? tai_pkg::C_DONE : tai_pkg::C_NORM;
      end
      tai_pkg::C_DONE:   if (out_free) state_next = tai_pkg::C_IDLE;
      default:           state_next = tai_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == tai_pkg::C_IDLE);
    rd           = '0;
    rd.idx_addr  = idx_base + tai_pkg::idx_addr_t'(cnt);
    rd.vtx_addr  = vtx[k];
    norm_start   = (state == tai_pkg::C_NORM);
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_dst      = '0;
    mul_neg      = 1'b0;
    case (state)
      tai_pkg::C_IDX: rd.idx_re = (cnt != 3'd3);
      tai_pkg::C_VTX: rd.vtx_re = 1'b1;
      tai_pkg::C_MAC: begin
        mul_en  = 1'b1;
        mul_b   = tai_pkg::q16_t'(w[k]);
        mul_dst = {1'b0, cnt};
        case (cnt)
          3'd0:    mul_a = vtx_rdata.nrm[0];
          3'd1:    mul_a = vtx_rdata.nrm[1];
          3'd2:    mul_a = vtx_rdata.nrm[2];
          3'd3:    mul_a = vtx_rdata.tan[0];
          3'd4:    mul_a = vtx_rdata.tan[1];
          3'd5:    mul_a = vtx_rdata.tan[2];
          3'd6:    mul_a = vtx_rdata.tex[0];
          default: mul_a = vtx_rdata.tex[1];
        endcase
      end
      tai_pkg::C_CROSS: begin
        mul_en  = 1'b1;
        mul_neg = cnt[0];
        case (cnt)
          3'd0:    begin mul_a = ev[1]; mul_b = ev[5]; mul_dst = tai_pkg::ACC_GX; end
          3'd1:    begin mul_a = ev[2]; mul_b = ev[4]; mul_dst = tai_pkg::ACC_GX; end
          3'd2:    begin mul_a = ev[2]; mul_b = ev[3]; mul_dst = tai_pkg::ACC_GY; end
          3'd3:    begin mul_a = ev[0]; mul_b = ev[5]; mul_dst = tai_pkg::ACC_GY; end
          3'd4:    begin mul_a = ev[0]; mul_b = ev[4]; mul_dst = tai_pkg::ACC_GZ; end
          default: begin mul_a = ev[1]; mul_b = ev[3]; mul_dst = tai_pkg::ACC_GZ; end
        endcase
      end
      default: begin
      end
    endcase
    case (nsel)
      2'd0:    for (int i = 0; i < 3; i++) norm_vec[i] = acc[tai_pkg::ACC_NX + 4'(i)];
      2'd1:    for (int i = 0; i < 3; i++) norm_vec[i] = acc[tai_pkg::ACC_TX + 4'(i)];
      default: for (int i = 0; i < 3; i++) norm_vec[i] = acc[tai_pkg::ACC_GX + 4'(i)];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tai_pkg::C_IDLE;
      prod_valid <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state      <= state_next;
      prod_valid <= mul_en;
      if (state == tai_pkg::C_DONE && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_dst <= mul_dst;
    prod_neg <= mul_neg;
    if (prod_valid) begin
      acc[prod_dst] <= prod_neg ? acc[prod_dst] - tai_pkg::acc_t'(prod)
                                : acc[prod_dst] + tai_pkg::acc_t'(prod);
    end
    case (state)
      tai_pkg::C_IDLE: begin
        cnt  <= '0;
        k    <= '0;
        nsel <= '0;
        if (accept) begin
          tri_num <= in_ch.item.triangle;
          w[0]    <= tai_pkg::wgt_t'(w0_full);
          w[1]    <= tai_pkg::wgt_t'({2'd0, in_ch.item.bary_u});
          w[2]    <= tai_pkg::wgt_t'({2'd0, in_ch.item.bary_v});
          for (int i = 0; i < tai_pkg::ACC_N; i++) acc[i] <= '0;
        end
      end
      tai_pkg::C_IDX: begin
        if (cnt != 3'd0) vtx[cnt_m1[1:0]] <= idx_rdata;
        cnt <= (cnt == 3'd3) ? 3'd0 : cnt + 3'd1;
      end
      tai_pkg::C_MAC: begin
        if (cnt == 3'd0) begin
          for (int c = 0; c < 3; c++) p[k][c] <= vtx_rdata.pos[c];
        end
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7 && k != 2'd2) k <= k + 2'd1;
      end
      tai_pkg::C_EDGE: begin
        for (int i = 0; i < 6; i++) begin
          esg[i]  <= d[i] < 0;
          emag[i] <= d[i] < 0 ? 32'(-d[i]) : 32'(d[i]);
        end
      end
      tai_pkg::C_ESCALE: begin
        if (ebig) begin
          for (int i = 0; i < 6; i++) emag[i] <= emag[i] >> 1;
        end
      end
      tai_pkg::C_CROSS: cnt <= cnt + 3'd1;
      tai_pkg::C_NWAIT: begin
        if (norm_done) begin
          nres[nsel] <= norm_res;
          nsel <= nsel + 2'd1;
        end
      end
      tai_pkg::C_DONE: begin
        if (out_free) begin
          out_ch.item.shade_nx <= nres[0][0];
          out_ch.item.shade_ny <= nres[0][1];
          out_ch.item.shade_nz <= nres[0][2];
          out_ch.item.tan_x    <= nres[1][0];
          out_ch.item.tan_y    <= nres[1][1];
          out_ch.item.tan_z    <= nres[1][2];
          out_ch.item.tex_s    <= tex[0];
          out_ch.item.tex_t    <= tex[1];
          out_ch.item.geo_nx   <= nres[2][0];
          out_ch.item.geo_ny   <= nres[2][1];
          out_ch.item.geo_nz   <= nres[2][2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/triangle_attribute_interpolator.sv
// Top level: mesh stores, query sequencer and normalizer.
//
//   channel  dir  payload                                    transfer
//   in_ch    in   action, slot, vertex, x/y/z, tri, u, v     valid & ready
//   out_ch   out  shade normal, tangent, texcoord, geo normal valid & ready
//
// A query runs fetch, multiply-accumulate and cross product, edge scaling shifts, and
// three runs of the shared normalizer, each with its scaling shifts, a 32-step square
// root and a 17-step divider, or none of these for a zero vector. Reset clears control
// only; the stores are undefined until written. A finished result waits in the output
// register while the next item is taken; a query finishing while that register is full
// holds.
module triangle_attribute_interpolator (
  input  logic        clk,
  input  logic        rst,
  tai_in_if.sink      in_ch,
  tai_out_if.source   out_ch
);

  tai_pkg::wr_t        wr;
  tai_pkg::rd_t        rd;
  tai_pkg::vtx_addr_t  idx_rdata;
  tai_pkg::vtx_data_t  vtx_rdata;
  logic                norm_start;
  logic                norm_done;
  tai_pkg::acc_t       norm_vec [3];
  tai_pkg::q16_t       norm_res [3];
  logic                accept;
  logic                idx_ok;
  logic                vtx_ok;

  assign accept = in_ch.valid && in_ch.ready;
  assign idx_ok = int'(in_ch.item.slot) < tai_pkg::IDX_DEPTH;
  assign vtx_ok = int'(in_ch.item.slot) < tai_pkg::VTX_DEPTH;

  always_comb begin
    wr          = '0;
    wr.idx_addr = tai_pkg::idx_addr_t'(in_ch.item.slot);
    wr.vtx_addr = tai_pkg::vtx_addr_t'(in_ch.item.slot);
    wr.vnum     = in_ch.item.vertex_number;
    wr.x        = in_ch.item.comp_x;
    wr.y        = in_ch.item.comp_y;
    wr.z        = in_ch.item.comp_z;
    if (accept) begin
      case (in_ch.item.action)
        tai_pkg::ACT_INDEX:    wr.idx_we = idx_ok;
        tai_pkg::ACT_POSITION: wr.pos_we = vtx_ok;
        tai_pkg::ACT_NORMAL:   wr.nrm_we = vtx_ok;
        tai_pkg::ACT_TANGENT:  wr.tan_we = vtx_ok;
        tai_pkg::ACT_TEXCOORD: wr.tex_we = vtx_ok;
        default: begin
        end
      endcase
    end
  end

  tai_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .idx_rdata (idx_rdata),
    .vtx_rdata (vtx_rdata)
  );

  tai_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vec   (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

  tai_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .rd         (rd),
    .idx_rdata  (idx_rdata),
    .vtx_rdata  (vtx_rdata),
    .norm_start (norm_start),
    .norm_vec   (norm_vec),
    .norm_done  (norm_done),
    .norm_res   (norm_res)
  );

endmodule

>>> sim/triangle_attribute_interpolator_checker.sv
// Checker: mirrors the mesh stores, predicts each query result and compares it.
`timescale 1ns / 100ps
module triangle_attribute_interpolator_checker (
  input  logic clk,
  input  logic rst,
  tai_in_if    in_ch,
  tai_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import tai_pkg::*;

  typedef longint vec_t [3];
  typedef q16_t   qvec_t [3];

  logic [9:0] index_mem [IDX_DEPTH];
  q16_t       pos_mem [VTX_DEPTH][3];
  q16_t       nrm_mem [VTX_DEPTH][3];
  q16_t       tan_mem [VTX_DEPTH][3];
  q16_t       tex_mem [VTX_DEPTH][2];
  out_item_t  expected_q [$];

  string field_names [11] = '{"shade_nx", "shade_ny", "shade_nz", "tan_x", "tan_y",
    "tan_z", "tex_s", "tex_t", "geo_nx", "geo_ny", "geo_nz"};

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic qvec_t to_unit(vec_t v);
    longint unsigned a [3];
    longint unsigned m, sum, len, q;
    qvec_t r;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return '{0, 0, 0};
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    len = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 65536 + len / 2) / len;
      r[i] = q16_t'(v[i] < 0 ? -q : q);
    end
    return r;
  endfunction

  function automatic out_item_t predict_query(in_item_t it);
    logic [9:0] vx [3];
    longint w [3];
    longint acc;
    longint e0 [3];
    longint e1 [3];
    longint unsigned m;
    vec_t sn, st, cr;
    qvec_t un, ut, ug;
    q16_t tc [2];
    out_item_t o;
    for (int k = 0; k < 3; k++) vx[k] = index_mem[int'(it.triangle) * 3 + k];
    w[1] = longint'(it.bary_u);
    w[2] = longint'(it.bary_v);
    w[0] = 65536 - w[1] - w[2];
    for (int c = 0; c < 3; c++) begin
      sn[c] = 0;
      st[c] = 0;
      for (int k = 0; k < 3; k++) begin
        sn[c] += longint'(nrm_mem[vx[k]][c]) * w[k];
        st[c] += longint'(tan_mem[vx[k]][c]) * w[k];
      end
    end
    un = to_unit(sn);
    ut = to_unit(st);
    for (int c = 0; c < 2; c++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += longint'(tex_mem[vx[k]][c]) * w[k];
      acc = (acc + 32768) >>> 16;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      tc[c] = q16_t'(acc);
    end
    m = 0;
    for (int c = 0; c < 3; c++) begin
      e0[c] = longint'(pos_mem[vx[1]][c]) - longint'(pos_mem[vx[0]][c]);
      e1[c] = longint'(pos_mem[vx[2]][c]) - longint'(pos_mem[vx[0]][c]);
      if (magnitude(e0[c]) > m) m = magnitude(e0[c]);
      if (magnitude(e1[c]) > m) m = magnitude(e1[c]);
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int c = 0; c < 3; c++) begin
        e0[c] = e0[c] < 0 ? -longint'(magnitude(e0[c]) >> 1) : longint'(magnitude(e0[c]) >> 1);
        e1[c] = e1[c] < 0 ? -longint'(magnitude(e1[c]) >> 1) : longint'(magnitude(e1[c]) >> 1);
      end
    end
    cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
    cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
    cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
    ug = to_unit(cr);
    o.shade_nx = un[0]; o.shade_ny = un[1]; o.shade_nz = un[2];
    o.tan_x = ut[0];    o.tan_y = ut[1];    o.tan_z = ut[2];
    o.tex_s = tc[0];    o.tex_t = tc[1];
    o.geo_nx = ug[0];   o.geo_ny = ug[1];   o.geo_nz = ug[2];
    return o;
  endfunction

  task automatic report(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $time, what);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    in_item_t  it;
    out_item_t want, got;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.item;
        if (expected_q.size() == 0) begin
          report($sformatf("result with nothing expected: %h", got));
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 11; i++)
            if (want[351 - 32 * i -: 32] !== got[351 - 32 * i -: 32])
              report($sformatf("%s expected %h actual %h", field_names[i],
                               want[351 - 32 * i -: 32], got[351 - 32 * i -: 32]));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.item;
        case (it.action)
          ACT_INDEX: if (it.slot < IDX_DEPTH) index_mem[it.slot] = it.vertex_number;
          ACT_POSITION: if (it.slot < VTX_DEPTH)
            pos_mem[it.slot[9:0]] = '{it.comp_x, it.comp_y, it.comp_z};
          ACT_NORMAL: if (it.slot < VTX_DEPTH)
            nrm_mem[it.slot[9:0]] = '{it.comp_x, it.comp_y, it.comp_z};
          ACT_TANGENT: if (it.slot < VTX_DEPTH)
            tan_mem[it.slot[9:0]] = '{it.comp_x, it.comp_y, it.comp_z};
          ACT_TEXCOORD: if (it.slot < VTX_DEPTH)
            tex_mem[it.slot[9:0]] = '{it.comp_x, it.comp_y};
          ACT_QUERY: expected_q = {expected_q, predict_query(it)};
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end
endmodule

>>> sim/triangle_attribute_interpolator_tb.sv
// Testbench top: clock, reset, mesh and query stimulus, and the verdict.
`timescale 1ns / 100ps
module triangle_attribute_interpolator_tb;
  import tai_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   stall_cycles;
  bit   quiet;

  bit         idx_written [IDX_DEPTH];
  logic [9:0] idx_value [IDX_DEPTH];
  bit   [3:0] vtx_written [VTX_DEPTH];

  tai_in_if  in_ch ();
  tai_out_if out_ch ();

  triangle_attribute_interpolator DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  triangle_attribute_interpolator_checker CHK (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ch.ready <= quiet || ($urandom_range(99) >= 7);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[triangle_attribute_interpolator] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t random_item();
    logic [191:0] bits;
    in_item_t it;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic q16_t pick_comp();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return q16_t'($urandom_range(262143)) - 32'sd131072;
      3: return q16_t'($urandom_range(16777215)) - 32'sd8388608;
      default: return q16_t'($urandom());
    endcase
  endfunction

  function automatic bit tri_ready(int t);
    for (int k = 0; k < 3; k++) begin
      if (!idx_written[t * 3 + k]) return 1'b0;
      if (vtx_written[idx_value[t * 3 + k]] != 4'hf) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int find_tri();
    int s;
    s = $urandom_range(31);
    if ($urandom_range(9) == 0 && tri_ready(1023)) return 1023;
    for (int k = 0; k < 32; k++)
      if (tri_ready((s + k) % 32)) return (s + k) % 32;
    return -1;
  endfunction

  task automatic send(input in_item_t it);
    while (!quiet && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_vertex(logic [2:0] act, int v, q16_t x, q16_t y, q16_t z);
    in_item_t it;
    it = random_item();
    it.action = act;
    it.slot = 12'(v);
    it.comp_x = x;
    it.comp_y = y;
    it.comp_z = z;
    if (v < VTX_DEPTH) vtx_written[v][act - ACT_POSITION] = 1'b1;
    send(it);
  endtask

  task automatic write_index(int s, int v);
    in_item_t it;
    it = random_item();
    it.action = ACT_INDEX;
    it.slot = 12'(s);
    it.vertex_number = 10'(v);
    if (s < IDX_DEPTH) begin
      idx_written[s] = 1'b1;
      idx_value[s] = 10'(v);
    end
    send(it);
  endtask

  task automatic query(int t, int u, int v);
    in_item_t it;
    it = random_item();
    it.action = ACT_QUERY;
    it.triangle = 10'(t);
    it.bary_u = 17'(u);
    it.bary_v = 17'(v);
    send(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    q16_t vals [4];
    int tri_verts [3][3];
    int tri_ids [3];
    int n, r, t, u;
    bit held;
    in_item_t it;
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'sh0001_8000};
    tri_verts = '{'{0, 1, 2}, '{2, 2, 2}, '{3, 0, 1}};
    tri_ids = '{0, 1, 1023};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int v = 0; v < 4; v++)
      for (int a = 0; a < 4; a++)
        write_vertex(3'(ACT_POSITION + a), v, vals[v], v == 3 ? -vals[v] : vals[v],
                     v == 3 ? 32'sd7 : vals[v]);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) write_index(tri_ids[i] * 3 + k, tri_verts[i][k]);
    query(0, 0, 0);
    query(0, 65536, 0);
    query(0, 0, 65536);
    query(0, 131071, 131071);
    query(1, 32768, 16384);
    query(1023, 32768, 32768);
    write_index(3072 + $urandom_range(1023), 5);
    write_vertex(ACT_NORMAL, 1024 + $urandom_range(3071), 1, 2, 3);
    it = random_item();
    it.action = 3'd6;
    send(it);
    it.action = 3'd7;
    send(it);

    held = 1'b0;
    n = 0;
    while (n < 650) begin
      quiet = (n >= 250 && n < 350);
      if (n == 400 && !held) begin
        held = 1'b1;
        drain();
      end
      r = $urandom_range(99);
      if (r < 5) begin
        it = random_item();
        case ($urandom_range(2))
          0: it.action = 3'(6 + $urandom_range(1));
          1: begin
            it.action = ACT_INDEX;
            it.slot = 12'($urandom_range(3072, 4095));
          end
          default: begin
            it.action = 3'(ACT_POSITION + $urandom_range(3));
            it.slot = 12'($urandom_range(1024, 4095));
          end
        endcase
        send(it);
      end else if (r < 40) begin
        write_vertex(3'(ACT_POSITION + $urandom_range(3)),
                     $urandom_range(19) == 0 ? $urandom_range(1023) : $urandom_range(31),
                     pick_comp(), pick_comp(), pick_comp());
        n++;
      end else if (r < 55) begin
        t = $urandom_range(19) == 0 ? 1023 :
            $urandom_range(19) == 0 ? $urandom_range(1023) : $urandom_range(31);
        write_index(t * 3 + $urandom_range(2),
                    $urandom_range(19) == 0 ? $urandom_range(1023) : $urandom_range(31));
        n++;
      end else begin
        t = find_tri();
        if (t >= 0) begin
          if ($urandom_range(9) == 0) begin
            query(t, $urandom_range(131071), $urandom_range(131071));
          end else begin
            u = $urandom_range(65536);
            query(t, u, $urandom_range(65536 - u));
          end
          n++;
        end
      end
    end

    quiet = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[triangle_attribute_interpolator] OK");
    end else begin
      $display("[triangle_attribute_interpolator] ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/tai_pkg.sv
rtl/tai_in_if.sv
rtl/tai_out_if.sv
rtl/tai_store.sv
rtl/tai_norm.sv
rtl/tai_ctrl.sv
rtl/triangle_attribute_interpolator.sv
sim/triangle_attribute_interpolator_checker.sv
sim/triangle_attribute_interpolator_tb.sv
